@@ hw/rtl/thc_pkg.sv @@
// shared types, codes and constants for the tier hysteresis controller
package thc_pkg;

  // width of the millisecond timer since the last switch
  localparam int unsigned TimerBits   = 32;
  // width the timer and cooldown are compared at
  localparam int unsigned CmpBits     = (TimerBits > 32) ? TimerBits : 32;
  // configuration port geometry
  localparam int unsigned CfgAddrBits = 3;
  localparam int unsigned CfgDataBits = 32;

  // sample clamp ceiling in percent
  localparam logic [6:0] PctMax = 7'd100;

  // register reset values
  localparam logic [5:0]  WindowRst    = 6'd3;
  localparam logic [31:0] CooldownRst  = 32'd5000;
  localparam logic [6:0]  ThrLowRst    = 7'd65;
  localparam logic [6:0]  ThrHighRst   = 7'd85;
  localparam logic [6:0]  ThrCritRst   = 7'd88;
  localparam logic        CooldownEnRst = 1'b1;

  typedef enum logic [1:0] {
    OP_EVAL  = 2'd0,
    OP_FORCE = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_NO_CHANGE = 3'd0,
    ST_BAND      = 3'd1,
    ST_COOLDOWN  = 3'd2,
    ST_CHANGED   = 3'd3,
    ST_FORCED    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    TIER_LOW      = 2'd0,
    TIER_MEDIUM   = 2'd1,
    TIER_HIGH     = 2'd2,
    TIER_CRITICAL = 2'd3
  } tier_e;

  typedef enum logic [1:0] {
    KERNEL_HEAVY = 2'd0,
    KERNEL_MID   = 2'd1,
    KERNEL_LIGHT = 2'd2
  } kernel_e;

  typedef enum logic [2:0] {
    CFG_WINDOW      = 3'd0,
    CFG_COOLDOWN    = 3'd1,
    CFG_THR_LOW     = 3'd2,
    CFG_THR_HIGH    = 3'd3,
    CFG_THR_CRIT    = 3'd4,
    CFG_COOLDOWN_EN = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0]  window;
    logic [31:0] cooldown;
    logic [6:0]  thr_low;
    logic [6:0]  thr_high;
    logic [6:0]  thr_crit;
    logic        cooldown_en;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic        changed;
    tier_e       tier;
    kernel_e     kernel;
    logic        dead_band;
    logic [31:0] switch_total;
    logic [31:0] suppress_total;
  } res_t;

  // workload code that goes with a tier
  function automatic kernel_e kernel_of(tier_e t);
    kernel_e k;
    case (t)
      TIER_HIGH, TIER_CRITICAL: k = KERNEL_HEAVY;
      TIER_MEDIUM:              k = KERNEL_MID;
      default:                  k = KERNEL_LIGHT;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/thc_cfg_regs.sv @@
// configuration register file with write-only access
module thc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [thc_pkg::CfgAddrBits-1:0]    cfg_index_i,
  input  logic [thc_pkg::CfgDataBits-1:0]    cfg_wdata_i,
  output thc_pkg::cfg_t                      cfg_o
);
  import thc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // index decode, values masked to register width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW:      cfg_d.window      = cfg_wdata_i[5:0];
        CFG_COOLDOWN:    cfg_d.cooldown    = cfg_wdata_i[31:0];
        CFG_THR_LOW:     cfg_d.thr_low     = cfg_wdata_i[6:0];
        CFG_THR_HIGH:    cfg_d.thr_high    = cfg_wdata_i[6:0];
        CFG_THR_CRIT:    cfg_d.thr_crit    = cfg_wdata_i[6:0];
        CFG_COOLDOWN_EN: cfg_d.cooldown_en = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window      <= WindowRst;
      cfg_q.cooldown    <= CooldownRst;
      cfg_q.thr_low     <= ThrLowRst;
      cfg_q.thr_high    <= ThrHighRst;
      cfg_q.thr_crit    <= ThrCritRst;
      cfg_q.cooldown_en <= CooldownEnRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/thc_core.sv @@
// tier decision logic and controller state
module thc_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          operation_i,
  input  logic signed [9:0]   usage_percent_i,
  input  logic [1:0]          forced_tier_i,
  input  thc_pkg::cfg_t       cfg_i,
  output logic                emit_o,
  output thc_pkg::res_t       res_o
);
  import thc_pkg::*;

  tier_e                 tier_q, tier_d;
  logic                  in_band_q, in_band_d;
  logic                  switched_q, switched_d;
  logic [TimerBits-1:0]  timer_q, timer_d;
  logic [31:0]           sw_cnt_q, sw_cnt_d;
  logic [31:0]           sup_cnt_q, sup_cnt_d;

  logic [6:0]  pct;
  tier_e       raw_tier;
  logic        near_low, near_high, blocked, cooling;
  status_e     status;
  logic        changed;

  // clamp sample to 0..100
  always_comb begin
    if (usage_percent_i[9]) begin
      pct = 7'd0;
    end else if (usage_percent_i[8:0] > {2'b00, PctMax}) begin
      pct = PctMax;
    end else begin
      pct = usage_percent_i[6:0];
    end
  end

  // classify, critical first
  always_comb begin
    if (pct >= cfg_i.thr_crit) begin
      raw_tier = TIER_CRITICAL;
    end else if (pct >= cfg_i.thr_high) begin
      raw_tier = TIER_HIGH;
    end else if (pct >= cfg_i.thr_low) begin
      raw_tier = TIER_MEDIUM;
    end else begin
      raw_tier = TIER_LOW;
    end
  end

  // dead band around the low and high thresholds
  assign near_low  = (({1'b0, pct} + {2'b00, cfg_i.window}) >= {1'b0, cfg_i.thr_low}) &&
                     ({1'b0, pct} <= ({1'b0, cfg_i.thr_low} + {2'b00, cfg_i.window}));
  assign near_high = (({1'b0, pct} + {2'b00, cfg_i.window}) >= {1'b0, cfg_i.thr_high}) &&
                     ({1'b0, pct} <= ({1'b0, cfg_i.thr_high} + {2'b00, cfg_i.window}));
  assign blocked =
      (near_low  && (((tier_q == TIER_LOW)    && (pct >= cfg_i.thr_low)) ||
                     ((tier_q == TIER_MEDIUM) && (pct <  cfg_i.thr_low)))) ||
      (near_high && (((tier_q == TIER_MEDIUM) && (pct >= cfg_i.thr_high)) ||
                     ((tier_q == TIER_HIGH)   && (pct <  cfg_i.thr_high))));

  // holdoff since the last switch
  assign cooling = cfg_i.cooldown_en && switched_q &&
                   (CmpBits'(timer_q) < CmpBits'(cfg_i.cooldown));

  // next state for one item
  always_comb begin
    tier_d     = tier_q;
    in_band_d  = in_band_q;
    switched_d = switched_q;
    timer_d    = timer_q;
    sw_cnt_d   = sw_cnt_q;
    sup_cnt_d  = sup_cnt_q;
    status     = ST_NO_CHANGE;
    changed    = 1'b0;
    emit_o     = 1'b0;
    case (operation_i)
      OP_TICK: begin
        if (timer_q != {TimerBits{1'b1}}) begin
          timer_d = timer_q + 1'b1;
        end
      end
      OP_FORCE: begin
        emit_o     = 1'b1;
        tier_d     = tier_e'(forced_tier_i);
        timer_d    = '0;
        switched_d = 1'b1;
        sw_cnt_d   = sw_cnt_q + 32'd1;
        in_band_d  = 1'b0;
        status     = ST_FORCED;
        changed    = 1'b1;
      end
      OP_EVAL: begin
        emit_o = 1'b1;
        if (raw_tier == tier_q) begin
          in_band_d = 1'b0;
          status    = ST_NO_CHANGE;
        end else if (blocked) begin
          in_band_d = 1'b1;
          sup_cnt_d = sup_cnt_q + 32'd1;
          status    = ST_BAND;
        end else if (cooling) begin
          sup_cnt_d = sup_cnt_q + 32'd1;
          status    = ST_COOLDOWN;
        end else begin
          tier_d     = raw_tier;
          timer_d    = '0;
          switched_d = 1'b1;
          sw_cnt_d   = sw_cnt_q + 32'd1;
          in_band_d  = 1'b0;
          status     = ST_CHANGED;
          changed    = 1'b1;
        end
      end
      default: emit_o = 1'b0;
    endcase
  end

  // result fields come from the state after the step
  always_comb begin
    res_o.status         = status;
    res_o.changed        = changed;
    res_o.tier           = tier_d;
    res_o.kernel         = kernel_of(tier_d);
    res_o.dead_band      = in_band_d;
    res_o.switch_total   = sw_cnt_d;
    res_o.suppress_total = sup_cnt_d;
  end

  // state update once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tier_q     <= TIER_LOW;
      in_band_q  <= 1'b0;
      switched_q <= 1'b0;
      timer_q    <= '0;
      sw_cnt_q   <= '0;
      sup_cnt_q  <= '0;
    end else if (step_i) begin
      tier_q     <= tier_d;
      in_band_q  <= in_band_d;
      switched_q <= switched_d;
      timer_q    <= timer_d;
      sw_cnt_q   <= sw_cnt_d;
      sup_cnt_q  <= sup_cnt_d;
    end
  end

endmodule

@@ hw/rtl/tier_hysteresis_controller_top.sv @@
// top level: input register, decision core and result register
//
// Usage: samples, forced-tier commands and millisecond ticks enter on the
// input channel (in_valid_i / in_stall_o). An evaluate or force item gives
// one result on the output channel (out_valid_o / out_stall_i); a tick or
// the unused operation code gives none. A transfer happens on a clock edge
// with valid high and stall low.
// Path: an item is registered in the input register at its transfer, is
// decided there, and its result is then held in the result register.
// Throughput: one item per cycle while the receiver does not stall; the single
// decision stage between the input and result registers sets that rate.
// Stalls: while the result register holds an untaken result and the
// receiver stalls, an item that would give a result waits in the input
// register and in_stall_o rises; ticks still pass.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at
// the next edge and must be made while the block is idle.
// Reset: both registers empty, tier low, counters and timer zero, and all
// configuration registers at their default values.
module tier_hysteresis_controller_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [thc_pkg::CfgAddrBits-1:0]   cfg_index_i,
  input  logic [thc_pkg::CfgDataBits-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        in_operation_i,
  input  logic signed [9:0]                 in_usage_percent_i,
  input  logic [1:0]                        in_forced_tier_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        out_status_o,
  output logic                              out_changed_o,
  output logic [1:0]                        out_tier_o,
  output logic [1:0]                        out_kernel_code_o,
  output logic                              out_dead_band_flag_o,
  output logic [31:0]                       out_switch_total_o,
  output logic [31:0]                       out_suppress_total_o
);
  import thc_pkg::*;

  cfg_t               cfg;
  logic               in_valid_q;
  logic [1:0]         op_q;
  logic signed [9:0]  usage_q;
  logic [1:0]         forced_q;
  logic               emit;
  logic               step;
  res_t               res;
  logic               out_valid_q;
  res_t               out_q;

  // configuration registers
  thc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // decision logic and state
  thc_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .operation_i     (op_q),
    .usage_percent_i (usage_q),
    .forced_tier_i   (forced_q),
    .cfg_i           (cfg),
    .emit_o          (emit),
    .res_o           (res)
  );

  // an item leaves the input register when its result has room
  assign step       = in_valid_q && (!emit || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q     <= in_operation_i;
      usage_q  <= in_usage_percent_i;
      forced_q <= in_forced_tier_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_status_o         = out_q.status;
  assign out_changed_o        = out_q.changed;
  assign out_tier_o           = out_q.tier;
  assign out_kernel_code_o    = out_q.kernel;
  assign out_dead_band_flag_o = out_q.dead_band;
  assign out_switch_total_o   = out_q.switch_total;
  assign out_suppress_total_o = out_q.suppress_total;

  // a held item stays in the input register
  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step |=> in_valid_q)
    else $error("input item dropped while stalled");

  // changed flag agrees with the status code
  a_changed_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_changed_o ==
      ((out_status_o == ST_CHANGED) || (out_status_o == ST_FORCED))))
    else $error("changed flag disagrees with status");

  // only a dead-band suppress leaves the band flag set, apart from cooldown
  a_band_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_status_o == ST_NO_CHANGE) || (out_status_o == ST_CHANGED) ||
                    (out_status_o == ST_FORCED)) |-> !out_dead_band_flag_o)
    else $error("dead band flag set on unsuppressed result");

  // kernel code follows the reported tier
  a_kernel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kernel_code_o == kernel_of(tier_e'(out_tier_o))))
    else $error("kernel code does not match tier");

endmodule

@@ bench/tb.sv @@
// self-checking bench for the tier hysteresis controller: directed table, then random phases
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import thc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 64;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASE_COUNT     = 9;
  localparam int PHASE_ITEMS     = 150;

  // one line of the directed table: a register write or an input item
  typedef struct {
    bit          is_cfg;
    cfg_idx_e    reg_idx;
    logic [31:0] reg_val;
    logic [1:0]  op;
    logic [9:0]  pct;
    logic [1:0]  ft;
    bit          typed;
    res_t        want;
  } step_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CfgAddrBits-1:0] cfg_index_i = '0;
  logic [CfgDataBits-1:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  in_operation_i = '0;
  logic [9:0]  in_usage_percent_i = '0;
  logic [1:0]  in_forced_tier_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  out_status_o;
  logic        out_changed_o;
  logic [1:0]  out_tier_o;
  logic [1:0]  out_kernel_code_o;
  logic        out_dead_band_flag_o;
  logic [31:0] out_switch_total_o;
  logic [31:0] out_suppress_total_o;

  // predictor state and its copy of the registers
  cfg_t model_cfg = '{WindowRst, CooldownRst, ThrLowRst, ThrHighRst, ThrCritRst, CooldownEnRst};
  tier_e                tier_q       = TIER_LOW;
  logic                 band_q       = 1'b0;
  logic                 switched_q   = 1'b0;
  logic [TimerBits-1:0] ms_q         = '0;
  logic [31:0]          switch_cnt   = '0;
  logic [31:0]          suppress_cnt = '0;

  res_t      tier_reports[$];
  step_row_t directed_rows[$];
  int        fail_count   = 0;
  int        quiet_cycles = 0;
  int        rx_stall_pct = 20;
  bit        hold_off_req = 1'b0;

  tier_hysteresis_controller_top i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .in_operation_i       (in_operation_i),
    .in_usage_percent_i   (in_usage_percent_i),
    .in_forced_tier_i     (in_forced_tier_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .out_status_o         (out_status_o),
    .out_changed_o        (out_changed_o),
    .out_tier_o           (out_tier_o),
    .out_kernel_code_o    (out_kernel_code_o),
    .out_dead_band_flag_o (out_dead_band_flag_o),
    .out_switch_total_o   (out_switch_total_o),
    .out_suppress_total_o (out_suppress_total_o)
  );

  // 10 ns clock
  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // switch the tier and restart the hold-off timer
  task automatic commit_tier(input tier_e t);
    tier_q     = t;
    ms_q       = '0;
    switched_q = 1'b1;
    switch_cnt = switch_cnt + 32'd1;
    band_q     = 1'b0;
  endtask

  // advance the tier state by one item and form the report it causes
  task automatic advance_tier_model(input logic [1:0] op, input logic [9:0] pct_raw,
                                    input logic [1:0] ft, output bit gives, output res_t r);
    int      p, w, lo, hi, crit;
    tier_e   raw_tier;
    status_e st;
    logic    changed;
    bit      band_hit;
    gives   = 1'b0;
    r       = '0;
    st      = ST_NO_CHANGE;
    changed = 1'b0;
    case (op)
      OP_TICK: begin
        if (~&ms_q) ms_q = ms_q + 1'b1;
      end
      OP_FORCE: begin
        commit_tier(tier_e'(ft));
        st      = ST_FORCED;
        changed = 1'b1;
        gives   = 1'b1;
      end
      OP_EVAL: begin
        gives = 1'b1;
        p     = int'($signed(pct_raw));
        if (p < 0) p = 0;
        if (p > int'(PctMax)) p = int'(PctMax);
        w    = int'(model_cfg.window);
        lo   = int'(model_cfg.thr_low);
        hi   = int'(model_cfg.thr_high);
        crit = int'(model_cfg.thr_crit);
        // critical first, then high, then low, whatever their order
        if (p >= crit) raw_tier = TIER_CRITICAL;
        else if (p >= hi) raw_tier = TIER_HIGH;
        else if (p >= lo) raw_tier = TIER_MEDIUM;
        else raw_tier = TIER_LOW;
        // dead band only blocks a move across the threshold it surrounds
        band_hit = 1'b0;
        if (p >= lo - w && p <= lo + w &&
            ((tier_q == TIER_LOW && p >= lo) || (tier_q == TIER_MEDIUM && p < lo)))
          band_hit = 1'b1;
        if (p >= hi - w && p <= hi + w &&
            ((tier_q == TIER_MEDIUM && p >= hi) || (tier_q == TIER_HIGH && p < hi)))
          band_hit = 1'b1;
        if (raw_tier == tier_q) begin
          band_q = 1'b0;
          st     = ST_NO_CHANGE;
        end else if (band_hit) begin
          band_q       = 1'b1;
          suppress_cnt = suppress_cnt + 32'd1;
          st           = ST_BAND;
        end else if (model_cfg.cooldown_en && switched_q && ms_q < model_cfg.cooldown) begin
          // band flag keeps its old value here
          suppress_cnt = suppress_cnt + 32'd1;
          st           = ST_COOLDOWN;
        end else begin
          commit_tier(raw_tier);
          st      = ST_CHANGED;
          changed = 1'b1;
        end
      end
      default: ;
    endcase
    r.status         = st;
    r.changed        = changed;
    r.tier           = tier_q;
    r.kernel         = (tier_q == TIER_LOW) ? KERNEL_LIGHT :
                       (tier_q == TIER_MEDIUM) ? KERNEL_MID : KERNEL_HEAVY;
    r.dead_band      = band_q;
    r.switch_total   = switch_cnt;
    r.suppress_total = suppress_cnt;
  endtask

  function automatic void check_field(string what, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // offer one item, hold it through stalls, predict at its transfer
  task automatic offer_item(input logic [1:0] op, input logic [9:0] pct, input logic [1:0] ft,
                            input bit typed, input res_t want);
    bit   gives;
    res_t predicted;
    in_valid_i         <= 1'b1;
    in_operation_i     <= op;
    in_usage_percent_i <= pct;
    in_forced_tier_i   <= ft;
    do @(negedge clk_i); while (in_stall_o);
    advance_tier_model(op, pct, ft, gives, predicted);
    if (gives) tier_reports.push_back(typed ? want : predicted);
    @(posedge clk_i);
  endtask

  // stop offering and let every outstanding report and tick drain
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (tier_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_WINDOW:      model_cfg.window      = val[5:0];
      CFG_COOLDOWN:    model_cfg.cooldown    = val;
      CFG_THR_LOW:     model_cfg.thr_low     = val[6:0];
      CFG_THR_HIGH:    model_cfg.thr_high    = val[6:0];
      CFG_THR_CRIT:    model_cfg.thr_crit    = val[6:0];
      CFG_COOLDOWN_EN: model_cfg.cooldown_en = val[0];
      default: ;
    endcase
  endtask

  function automatic step_row_t item_row(logic [1:0] op, logic [9:0] pct, logic [1:0] ft);
    step_row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = CFG_WINDOW;
    r.reg_val = '0;
    r.op      = op;
    r.pct     = pct;
    r.ft      = ft;
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic step_row_t checked_row(logic [1:0] op, logic [9:0] pct, logic [1:0] ft,
                                            res_t want);
    step_row_t r;
    r       = item_row(op, pct, ft);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic step_row_t cfg_row(cfg_idx_e idx, logic [31:0] val);
    step_row_t r;
    r         = item_row(OP_EVAL, '0, '0);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // receiver stall: random short bursts, and one long hold-off on request
  initial begin : result_backpressure
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i  <= 1'b0;
        hold_off_req = 1'b0;
      end else if ($urandom_range(1, 100) <= rx_stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // compare each result transfer with the oldest report, and watch for a hang
  always @(negedge clk_i) begin : report_checker
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (tier_reports.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d tier %0d",
                   $time, out_status_o, out_tier_o);
          fail_count++;
        end else begin
          want = tier_reports.pop_front();
          check_field("status", want.status, out_status_o);
          check_field("changed", want.changed, out_changed_o);
          check_field("tier", want.tier, out_tier_o);
          check_field("kernel_code", want.kernel, out_kernel_code_o);
          check_field("dead_band_flag", want.dead_band, out_dead_band_flag_o);
          check_field("switch_total", want.switch_total, out_switch_total_o);
          check_field("suppress_total", want.suppress_total, out_suppress_total_o);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int          ph, k, v, c, wd, gap_pct, sel;
    bit          calm;
    logic [1:0]  op, ft;
    logic [9:0]  pct;
    logic [31:0] cw, ccd, clo, chi, ccr, cen;

    // directed table, reset register values until the first write row
    directed_rows.push_back(checked_row(OP_EVAL, 10'd0, 2'd0,
      '{ST_NO_CHANGE, 1'b0, TIER_LOW, KERNEL_LIGHT, 1'b0, 32'd0, 32'd0}));
    directed_rows.push_back(checked_row(OP_EVAL, 10'h200, 2'd1,
      '{ST_NO_CHANGE, 1'b0, TIER_LOW, KERNEL_LIGHT, 1'b0, 32'd0, 32'd0}));
    directed_rows.push_back(checked_row(OP_EVAL, 10'd66, 2'd2,
      '{ST_BAND, 1'b0, TIER_LOW, KERNEL_LIGHT, 1'b1, 32'd0, 32'd1}));
    directed_rows.push_back(checked_row(OP_EVAL, 10'd64, 2'd3,
      '{ST_NO_CHANGE, 1'b0, TIER_LOW, KERNEL_LIGHT, 1'b0, 32'd0, 32'd1}));
    // first switch goes through with no cooldown check
    directed_rows.push_back(checked_row(OP_EVAL, 10'd511, 2'd0,
      '{ST_CHANGED, 1'b1, TIER_CRITICAL, KERNEL_HEAVY, 1'b0, 32'd1, 32'd1}));
    directed_rows.push_back(checked_row(OP_EVAL, 10'd70, 2'd0,
      '{ST_COOLDOWN, 1'b0, TIER_CRITICAL, KERNEL_HEAVY, 1'b0, 32'd1, 32'd2}));
    directed_rows.push_back(checked_row(OP_FORCE, 10'd33, 2'd0,
      '{ST_FORCED, 1'b1, TIER_LOW, KERNEL_LIGHT, 1'b0, 32'd2, 32'd2}));
    directed_rows.push_back(item_row(OP_TICK, 10'h155, 2'd2));
    directed_rows.push_back(item_row(OP_UNUSED, 10'h2aa, 2'd3));
    directed_rows.push_back(checked_row(OP_FORCE, 10'h3ff, 2'd3,
      '{ST_FORCED, 1'b1, TIER_CRITICAL, KERNEL_HEAVY, 1'b0, 32'd3, 32'd2}));
    directed_rows.push_back(checked_row(OP_FORCE, 10'd0, 2'd1,
      '{ST_FORCED, 1'b1, TIER_MEDIUM, KERNEL_MID, 1'b0, 32'd4, 32'd2}));
    directed_rows.push_back(checked_row(OP_FORCE, 10'd0, 2'd2,
      '{ST_FORCED, 1'b1, TIER_HIGH, KERNEL_HEAVY, 1'b0, 32'd5, 32'd2}));
    directed_rows.push_back(checked_row(OP_EVAL, 10'd84, 2'd0,
      '{ST_BAND, 1'b0, TIER_HIGH, KERNEL_HEAVY, 1'b1, 32'd5, 32'd3}));
    // cooldown suppress keeps the band flag set
    directed_rows.push_back(checked_row(OP_EVAL, 10'd100, 2'd0,
      '{ST_COOLDOWN, 1'b0, TIER_HIGH, KERNEL_HEAVY, 1'b1, 32'd5, 32'd4}));
    directed_rows.push_back(checked_row(OP_EVAL, 10'd87, 2'd0,
      '{ST_NO_CHANGE, 1'b0, TIER_HIGH, KERNEL_HEAVY, 1'b0, 32'd5, 32'd4}));
    directed_rows.push_back(checked_row(OP_EVAL, 10'h3ff, 2'd0,
      '{ST_COOLDOWN, 1'b0, TIER_HIGH, KERNEL_HEAVY, 1'b0, 32'd5, 32'd5}));
    directed_rows.push_back(cfg_row(CFG_COOLDOWN, 32'd0));
    directed_rows.push_back(item_row(OP_EVAL, 10'd50, 2'd0));
    directed_rows.push_back(cfg_row(CFG_WINDOW, 32'd63));
    directed_rows.push_back(item_row(OP_EVAL, 10'd90, 2'd0));
    // cooldown off, zero window, thresholds at the edges, upper data bits masked
    directed_rows.push_back(cfg_row(CFG_COOLDOWN_EN, 32'hffff_fffe));
    directed_rows.push_back(cfg_row(CFG_COOLDOWN, 32'hffff_ffff));
    directed_rows.push_back(cfg_row(CFG_WINDOW, 32'hffff_ffc0));
    directed_rows.push_back(cfg_row(CFG_THR_LOW, 32'd0));
    directed_rows.push_back(cfg_row(CFG_THR_HIGH, 32'hffff_ff7f));
    directed_rows.push_back(cfg_row(CFG_THR_CRIT, 32'd100));
    directed_rows.push_back(item_row(OP_EVAL, 10'd0, 2'd0));
    directed_rows.push_back(item_row(OP_EVAL, 10'd100, 2'd0));
    directed_rows.push_back(item_row(OP_TICK, 10'h0ff, 2'd1));
    directed_rows.push_back(item_row(OP_FORCE, 10'h1ff, 2'd0));
    directed_rows.push_back(item_row(OP_EVAL, 10'h1ff, 2'd0));

    // reset
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle_block();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        offer_item(directed_rows[i].op, directed_rows[i].pct, directed_rows[i].ft,
                   directed_rows[i].typed, directed_rows[i].want);
      end
    end

    // random phases, each under its own register setting
    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      settle_block();
      cw  = 32'd3;
      ccd = 32'd4;
      clo = 32'd65;
      chi = 32'd85;
      ccr = 32'd88;
      cen = 32'd1;
      case (ph)
        1: begin
          cw  = 32'd0;
          ccd = 32'd0;
        end
        2: begin
          cw  = 32'd50;
          ccd = 32'd10;
          clo = 32'd40;
          chi = 32'd60;
          ccr = 32'd80;
        end
        3: begin
          cw  = $urandom_range(0, 10);
          ccd = $urandom_range(0, 20);
          clo = $urandom_range(0, 60);
          chi = clo + $urandom_range(0, 30);
          ccr = chi + $urandom_range(0, 100 - chi);
          cen = $urandom_range(0, 1);
        end
        4: begin
          cw  = $urandom;
          ccd = $urandom;
          clo = $urandom;
          chi = $urandom;
          ccr = $urandom;
          cen = $urandom;
        end
        5: begin
          cw  = 32'd5;
          ccd = 32'hffff_ffff;
        end
        6: begin
          cw  = 32'd2;
          ccd = 32'hffff_ffff;
          clo = $urandom_range(0, 127);
          chi = $urandom_range(0, 127);
          ccr = $urandom_range(0, 127);
          cen = 32'd0;
        end
        7: begin
          cw  = 32'd1;
          ccd = 32'd2;
          clo = 32'd0;
          chi = 32'd100;
          ccr = 32'd100;
        end
        8: begin
          ccd = 32'd5000;
        end
        default: ;
      endcase
      write_reg(CFG_WINDOW, cw);
      write_reg(CFG_COOLDOWN, ccd);
      write_reg(CFG_THR_LOW, clo);
      write_reg(CFG_THR_HIGH, chi);
      write_reg(CFG_THR_CRIT, ccr);
      write_reg(CFG_COOLDOWN_EN, cen);

      k       = 0;
      gap_pct = 25;
      while (k < PHASE_ITEMS) begin
        // idle pattern changes every 30 items; the last phase runs flat out
        if (k % 30 == 0) begin
          calm         = ($urandom_range(0, 2) == 0) || (ph == PHASE_COUNT - 1);
          gap_pct      = calm ? 0 : 25;
          rx_stall_pct = calm ? 0 : 25;
        end
        if (ph == 1 && k == 40) hold_off_req = 1'b1;
        if (ph == 3 && k == 75) settle_block();

        sel = $urandom_range(0, 99);
        if (sel < 55) op = OP_EVAL;
        else if (sel < 85) op = OP_TICK;
        else if (sel < 95) op = OP_FORCE;
        else op = OP_UNUSED;
        ft = $urandom_range(0, 3);

        // samples mostly around a threshold, some anywhere in range, a few wild
        wd  = int'(model_cfg.window) + 2;
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
          case ($urandom_range(0, 2))
            0:       c = int'(model_cfg.thr_low);
            1:       c = int'(model_cfg.thr_high);
            default: c = int'(model_cfg.thr_crit);
          endcase
          v = c + int'($urandom_range(0, 2 * wd)) - wd;
        end else if (sel < 9) begin
          v = $urandom_range(0, 100);
        end else begin
          v = int'($urandom_range(0, 1023)) - 512;
        end
        pct = v[9:0];

        offer_item(op, pct, ft, 1'b0, '0);
        if (op != OP_UNUSED) k++;
        if ($urandom_range(1, 100) <= gap_pct) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 4)) @(posedge clk_i);
        end
      end
    end

    settle_block();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/thc_pkg.sv
hw/rtl/thc_cfg_regs.sv
hw/rtl/thc_core.sv
hw/rtl/tier_hysteresis_controller_top.sv
bench/tb.sv
